@@ rtl/rca_pkg.sv @@
// Package for the reference-counted ID allocator: sizes, codes, transaction
// types and the controller state type.
// Depends on nothing; the allocator, the checker and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package rca_pkg;

  // Table sizing
  localparam int unsigned MAX_IDS    = 1024;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned IdW        = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned LvlW       = $clog2(MAX_IDS + 1);

  // Field widths of the transactions
  localparam int unsigned ReqIdW  = 10;
  localparam int unsigned RspCntW = 16;

  typedef logic [IdW-1:0]        id_t;
  typedef logic [LvlW-1:0]       lvl_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t CountMax = '1;

  // Request codes
  localparam logic [1:0] REQ_ALLOC    = 2'd0;
  localparam logic [1:0] REQ_CLAIM    = 2'd1;
  localparam logic [1:0] REQ_RELEASE  = 2'd2;
  localparam logic [1:0] REQ_RETARGET = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ReqIdW-1:0] target_id;
    logic [ReqIdW-1:0] current_id;
  } req_t;

  typedef struct packed {
    logic [ReqIdW-1:0]  result_id;
    logic [RspCntW-1:0] ref_count;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ALLOC_POP,
    S_FILL,
    S_CLAIM_CHK,
    S_SCAN,
    S_REL_CHK,
    S_RT_CUR,
    S_RT_TGT,
    S_RT_WR
  } fsm_e;

endpackage

`default_nettype wire

@@ rtl/rca_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rca_ram #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/refcounted_id_allocator.sv @@
// Top level of the reference-counted ID allocator: controller plus the count
// and free-stack memories.
// Depends on rca_pkg and rca_ram.
`timescale 1ns / 1ps
`default_nettype none

// Hands out IDs and keeps a reference count for each one. A request is
// accepted when start_i is high while busy_o is low; exactly one result
// follows, shown on rsp_o for a single cycle with done_o high. The receiver
// cannot stall: sample rsp_o whenever done_o is high. done_o rises in the
// same cycle that busy_o falls, and a new request may be accepted in that
// same cycle. Counts live in a 1024 x 16 RAM and the free stack in a
// 1024 x 10 RAM, both with one read and one write per cycle and registered
// read data, so the work of a request is a short sequence of reads and
// write-backs. An allocate that creates a new ID and any error caught on
// the high-water mark or the table size finish in the dispatch state; an
// allocate that pops the free stack, a release, and a claim of an ID that
// is held read first and then write back. A retarget reads the old count,
// then the new one, then writes back the old count and then the new one
// (the two reads and two write-backs share the count RAM port); it stops
// after the first read when the old ID has no references, and after the
// second when the new ID has none, on overflow or when both IDs are the
// same. A claim beyond the high-water mark writes one new free ID per
// cycle. A claim of a freed ID walks the free stack to pull it out in order.
// After reset the block is ready at once; no clearing pass is needed, since
// only entries already written are ever read.
module refcounted_id_allocator
  import rca_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output rsp_t      rsp_o
);

  // Control state
  fsm_e  state_q, state_d;
  lvl_t  created_q, created_d;
  lvl_t  level_q, level_d;
  lvl_t  scan_idx_q, scan_idx_d;
  logic  scan_pend_q, scan_pend_d;
  lvl_t  scan_pidx_q, scan_pidx_d;
  logic  found_q, found_d;
  logic  done_q, done_d;

  // Payload registers
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  count_t cnt_cur_q, cnt_cur_d;
  count_t cnt_tgt_q, cnt_tgt_d;

  // Memory ports
  logic   cnt_we, cnt_re, stk_we, stk_re;
  id_t    cnt_waddr, cnt_raddr, stk_waddr, stk_raddr;
  count_t cnt_wdata, cnt_rdata;
  id_t    stk_wdata, stk_rdata;

  rca_ram #(
    .DataW (COUNT_BITS),
    .Depth (MAX_IDS)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  rca_ram #(
    .DataW (IdW),
    .Depth (MAX_IDS)
  ) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Request fields widened for range checks against the table bounds
  logic [31:0] tgt_w, cur_w, created_w;
  id_t         tgt_id, cur_id;

  assign tgt_w     = 32'(req_q.target_id);
  assign cur_w     = 32'(req_q.current_id);
  assign created_w = 32'(created_q);
  assign tgt_id    = IdW'(req_q.target_id);
  assign cur_id    = IdW'(req_q.current_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      created_q   <= '0;
      level_q     <= '0;
      scan_idx_q  <= '0;
      scan_pend_q <= 1'b0;
      scan_pidx_q <= '0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      created_q   <= created_d;
      level_q     <= level_d;
      scan_idx_q  <= scan_idx_d;
      scan_pend_q <= scan_pend_d;
      scan_pidx_q <= scan_pidx_d;
      found_q     <= found_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      req_q <= req_i;
    end
    rsp_q     <= rsp_d;
    cnt_cur_q <= cnt_cur_d;
    cnt_tgt_q <= cnt_tgt_d;
  end

  always_comb begin
    count_t cnt_new;

    state_d     = state_q;
    created_d   = created_q;
    level_d     = level_q;
    scan_idx_d  = scan_idx_q;
    scan_pend_d = 1'b0;
    scan_pidx_d = scan_pidx_q;
    found_d     = found_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    cnt_cur_d   = cnt_cur_q;
    cnt_tgt_d   = cnt_tgt_q;
    cnt_new     = '0;

    cnt_we    = 1'b0;
    cnt_waddr = tgt_id;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = tgt_id;
    stk_we    = 1'b0;
    stk_waddr = IdW'(level_q);
    stk_wdata = tgt_id;
    stk_re    = 1'b0;
    stk_raddr = IdW'(level_q - lvl_t'(1));

    // Default result shape is the error form: target id, zero count
    rsp_d.result_id = req_q.target_id;
    rsp_d.ref_count = '0;
    rsp_d.status    = ST_INVALID;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (req_q.req_type)
          REQ_ALLOC: begin
            if (level_q != '0) begin
              // Pop the top of the free stack
              stk_re  = 1'b1;
              state_d = S_ALLOC_POP;
            end else if (created_q < lvl_t'(MAX_IDS)) begin
              cnt_we          = 1'b1;
              cnt_waddr       = IdW'(created_q);
              cnt_wdata       = count_t'(1);
              created_d       = created_q + lvl_t'(1);
              rsp_d.result_id = ReqIdW'(created_q);
              rsp_d.ref_count = RspCntW'(1);
              rsp_d.status    = ST_OK;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end else begin
              rsp_d.result_id = '0;
              rsp_d.status    = ST_FULL;
              done_d          = 1'b1;
              state_d         = S_IDLE;
            end
          end

          REQ_CLAIM: begin
            if (tgt_w >= 32'(MAX_IDS)) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (tgt_w >= created_w) begin
              state_d = S_FILL;
            end else begin
              cnt_re  = 1'b1;
              state_d = S_CLAIM_CHK;
            end
          end

          REQ_RELEASE: begin
            if (tgt_w >= created_w) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              cnt_re  = 1'b1;
              state_d = S_REL_CHK;
            end
          end

          REQ_RETARGET: begin
            if (cur_w >= created_w || tgt_w >= created_w) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              cnt_re    = 1'b1;
              cnt_raddr = cur_id;
              state_d   = S_RT_CUR;
            end
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_ALLOC_POP: begin
        cnt_we          = 1'b1;
        cnt_waddr       = stk_rdata;
        cnt_wdata       = count_t'(1);
        level_d         = level_q - lvl_t'(1);
        rsp_d.result_id = ReqIdW'(stk_rdata);
        rsp_d.ref_count = RspCntW'(1);
        rsp_d.status    = ST_OK;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      S_FILL: begin
        if (created_w < tgt_w) begin
          // Create one skipped ID per cycle as free
          cnt_we    = 1'b1;
          cnt_waddr = IdW'(created_q);
          cnt_wdata = '0;
          if (level_q < lvl_t'(MAX_IDS)) begin
            stk_we    = 1'b1;
            stk_waddr = IdW'(level_q);
            stk_wdata = IdW'(created_q);
            level_d   = level_q + lvl_t'(1);
          end
          created_d = created_q + lvl_t'(1);
        end else begin
          cnt_we          = 1'b1;
          cnt_waddr       = tgt_id;
          cnt_wdata       = count_t'(1);
          created_d       = lvl_t'(tgt_w + 32'd1);
          rsp_d.ref_count = RspCntW'(1);
          rsp_d.status    = ST_OK;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end

      S_CLAIM_CHK: begin
        if (cnt_rdata == CountMax) begin
          rsp_d.status = ST_OVERFLOW;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else if (cnt_rdata == '0) begin
          // A freed ID sits on the stack exactly once: pull it out in order
          scan_idx_d = '0;
          found_d    = 1'b0;
          state_d    = S_SCAN;
        end else begin
          cnt_new         = cnt_rdata + count_t'(1);
          cnt_we          = 1'b1;
          cnt_wdata       = cnt_new;
          rsp_d.ref_count = RspCntW'(cnt_new);
          rsp_d.status    = ST_OK;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end

      S_SCAN: begin
        // Stream reads bottom-up; after the match, shift each entry down one
        if (scan_idx_q < level_q) begin
          stk_re      = 1'b1;
          stk_raddr   = IdW'(scan_idx_q);
          scan_idx_d  = scan_idx_q + lvl_t'(1);
          scan_pend_d = 1'b1;
          scan_pidx_d = scan_idx_q;
        end
        if (scan_pend_q) begin
          if (!found_q) begin
            if (stk_rdata == tgt_id) begin
              found_d = 1'b1;
            end
          end else begin
            stk_we    = 1'b1;
            stk_waddr = IdW'(scan_pidx_q - lvl_t'(1));
            stk_wdata = stk_rdata;
          end
        end
        if (!scan_pend_q && scan_idx_q == level_q) begin
          if (found_q) begin
            level_d = level_q - lvl_t'(1);
          end
          cnt_we          = 1'b1;
          cnt_wdata       = count_t'(1);
          rsp_d.ref_count = RspCntW'(1);
          rsp_d.status    = ST_OK;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end

      S_REL_CHK: begin
        if (cnt_rdata != '0) begin
          cnt_new   = cnt_rdata - count_t'(1);
          cnt_we    = 1'b1;
          cnt_wdata = cnt_new;
          if (cnt_new == '0 && level_q < lvl_t'(MAX_IDS)) begin
            stk_we  = 1'b1;
            level_d = level_q + lvl_t'(1);
          end
          rsp_d.ref_count = RspCntW'(cnt_new);
          rsp_d.status    = ST_OK;
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_RT_CUR: begin
        if (cnt_rdata == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_cur_d = cnt_rdata;
          cnt_re    = 1'b1;
          state_d   = S_RT_TGT;
        end
      end

      S_RT_TGT: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (cnt_rdata == '0) begin
          rsp_d.status = ST_INVALID;
        end else if (cur_id == tgt_id) begin
          if (cnt_rdata != count_t'(1)) begin
            rsp_d.ref_count = RspCntW'(cnt_rdata);
            rsp_d.status    = ST_OK;
          end
        end else if (cnt_rdata == CountMax) begin
          rsp_d.status = ST_OVERFLOW;
        end else begin
          // Drop the old reference now, add the new one next cycle
          cnt_new   = cnt_cur_q - count_t'(1);
          cnt_we    = 1'b1;
          cnt_waddr = cur_id;
          cnt_wdata = cnt_new;
          if (cnt_new == '0 && level_q < lvl_t'(MAX_IDS)) begin
            stk_we    = 1'b1;
            stk_wdata = cur_id;
            level_d   = level_q + lvl_t'(1);
          end
          cnt_tgt_d = cnt_rdata + count_t'(1);
          done_d    = 1'b0;
          state_d   = S_RT_WR;
        end
      end

      S_RT_WR: begin
        cnt_we          = 1'b1;
        cnt_wdata       = cnt_tgt_q;
        rsp_d.ref_count = RspCntW'(cnt_tgt_q);
        rsp_d.status    = ST_OK;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

@@ rtl/rca_checker.sv @@
// Port-level checker for the reference-counted ID allocator, bound to the
// top level. Depends on rca_pkg and refcounted_id_allocator.
`timescale 1ns / 1ps
`default_nettype none

module rca_checker
  import rca_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire req_t req_i,
  input wire logic busy_o,
  input wire logic done_o,
  input wire rsp_t rsp_o
);

  // A result strobe only shows once the controller is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  // Finishing a transaction always delivers its result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // One result per transaction: strobes never run back to back
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // Error results carry a zero count
  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.ref_count == '0))
    else $error("error result with nonzero count");

endmodule

bind refcounted_id_allocator rca_checker u_rca_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for refcounted_id_allocator: a scoreboard class
// that predicts every result from its own copy of the count table and free
// stack. Depends on rca_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb;
  import rca_pkg::*;

  // Slowest legal run: about 1450 transactions, some walking a long free
  // stack, one full-table fill and a long gap now and then. Allow several
  // times that.
  localparam int unsigned CycleLimit = 600_000;
  // Most random traffic stays on low IDs so the free stack stays short.
  localparam int unsigned Window     = 64;
  // Random traffic plus the full-table drain add up to about 1450 items.
  localparam int unsigned RandItems  = 430;
  localparam int unsigned TopId      = 1023;

  class refcount_board;
    count_t      counts[MAX_IDS];
    int unsigned created_n;
    id_t         free_q[$];
    rsp_t        want_q[$];
    int unsigned errors;

    function bit is_held(int unsigned id);
      return id < created_n && counts[id] != '0;
    endfunction

    // Advance the table by one transaction and return the result it gives.
    function rsp_t apply_request(req_t r);
      rsp_t        o;
      id_t         id;
      int unsigned t;
      int unsigned c;
      int          hit[$];
      t = 32'(r.target_id);
      c = 32'(r.current_id);
      o.result_id = r.target_id;
      o.ref_count = '0;
      o.status    = ST_INVALID;
      case (r.req_type)
        REQ_ALLOC: begin
          o.result_id = '0;
          if (free_q.size() > 0) begin
            id = free_q.pop_back();
          end else if (created_n < MAX_IDS) begin
            id = id_t'(created_n);
            created_n++;
          end else begin
            o.status = ST_FULL;
            return o;
          end
          counts[id]  = count_t'(1);
          o.result_id = id;
          o.ref_count = RspCntW'(1);
          o.status    = ST_OK;
        end
        REQ_CLAIM: begin
          if (t >= MAX_IDS) return o;
          if (t >= created_n) begin
            // Create the gap below the target as free IDs, lowest first.
            for (int unsigned i = created_n; i < t; i++) begin
              counts[i] = '0;
              if (free_q.size() < MAX_IDS) free_q.push_back(id_t'(i));
            end
            counts[t]   = count_t'(1);
            created_n   = t + 1;
            o.ref_count = RspCntW'(1);
            o.status    = ST_OK;
            return o;
          end
          if (counts[t] == CountMax) begin
            o.status = ST_OVERFLOW;
            return o;
          end
          hit = free_q.find_first_index(x) with (x == id_t'(t));
          if (hit.size() > 0) free_q.delete(hit[0]);
          counts[t]++;
          o.ref_count = counts[t];
          o.status    = ST_OK;
        end
        REQ_RELEASE: begin
          if (!is_held(t)) return o;
          counts[t]--;
          if (counts[t] == '0 && free_q.size() < MAX_IDS) free_q.push_back(id_t'(t));
          o.ref_count = counts[t];
          o.status    = ST_OK;
        end
        default: begin
          if (!is_held(c) || !is_held(t)) return o;
          if (c == t) begin
            // Same ID on both sides: drop and re-add a reference, unless that
            // would pass through zero.
            if (counts[t] == count_t'(1)) return o;
            o.ref_count = counts[t];
            o.status    = ST_OK;
            return o;
          end
          if (counts[t] == CountMax) begin
            o.status = ST_OVERFLOW;
            return o;
          end
          counts[c]--;
          if (counts[c] == '0 && free_q.size() < MAX_IDS) free_q.push_back(id_t'(c));
          counts[t]++;
          o.ref_count = counts[t];
          o.status    = ST_OK;
        end
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      want_q.push_back(apply_request(r));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got id %0d count %0d status %0d",
                 $time, got.result_id, got.ref_count, got.status);
        return;
      end
      want = want_q.pop_front();
      if (got.result_id !== want.result_id)
        report("result_id", 32'(want.result_id), 32'(got.result_id));
      if (got.ref_count !== want.ref_count)
        report("ref_count", 32'(want.ref_count), 32'(got.ref_count));
      if (got.status !== want.status)
        report("status", 32'(want.status), 32'(got.status));
    endfunction

    // A random ID that currently holds references, or a low one if none does.
    function int unsigned pick_held();
      int unsigned ids[$];
      for (int unsigned i = 0; i < created_n; i++)
        if (counts[i] != '0) ids.push_back(i);
      if (ids.size() == 0) return $urandom_range(0, Window - 1);
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function int unsigned pick_freed();
      if (free_q.size() == 0) return pick_held();
      return 32'(free_q[$urandom_range(0, free_q.size() - 1)]);
    endfunction
  endclass

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start_i = 1'b0;
  req_t          req_i   = '0;
  logic          busy_o;
  logic          done_o;
  rsp_t          rsp_o;
  int unsigned   cycles  = 0;
  refcount_board board;

  refcounted_id_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or a result never shows up.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Results cannot be held off: take every strobe as it comes.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_response(rsp_o);
  end

  function automatic req_t mk(logic [1:0] op, int unsigned tgt, int unsigned cur);
    req_t r;
    r.req_type   = op;
    r.target_id  = tgt[ReqIdW-1:0];
    r.current_id = cur[ReqIdW-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hold start and the request until the block takes it, then log it.
  task automatic send(req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    board.note_request(r);
  endtask

  task automatic pause(int unsigned n);
    if (n == 0) return;
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic issue(req_t r, bit idle_ok);
    send(r);
    if (idle_ok) pause(gap_len());
  endtask

  // Drop start and wait out every outstanding result.
  task automatic drain();
    start_i <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic on live IDs, with some noise on any ID.
  function automatic req_t rand_request();
    int unsigned p;
    int unsigned q;
    int unsigned tgt;
    int unsigned cur;
    p = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    if (p < 25) return mk(REQ_ALLOC, $urandom_range(0, TopId), $urandom_range(0, TopId));
    if (p < 40) begin
      if (q < 40) tgt = board.pick_held();
      else if (q < 70) tgt = board.pick_freed();
      else if (board.created_n < Window)
        tgt = board.created_n + $urandom_range(0, 3);
      else tgt = $urandom_range(0, Window - 1);
      if (tgt >= Window && tgt >= board.created_n) tgt = Window - 1;
      return mk(REQ_CLAIM, tgt, $urandom_range(0, TopId));
    end
    if (p < 70) begin
      if (q < 80) tgt = board.pick_held();
      else if (q < 90) tgt = board.pick_freed();
      else tgt = $urandom_range(0, TopId);
      return mk(REQ_RELEASE, tgt, $urandom_range(0, TopId));
    end
    cur = (q < 80) ? board.pick_held() : $urandom_range(0, TopId);
    q = $urandom_range(0, 99);
    if (q < 15) tgt = cur;
    else if (q < 75) tgt = board.pick_held();
    else if (q < 85) tgt = board.pick_freed();
    else tgt = $urandom_range(0, TopId);
    return mk(REQ_RETARGET, tgt, cur);
  endfunction

  initial begin
    bit burst;
    board = new();
    burst = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: errors on an empty table, creation, stack order, and every
    // retarget corner.
    issue(mk(REQ_RELEASE, 0, 0), 1'b1);     // release of an uncreated ID
    issue(mk(REQ_RETARGET, 0, 0), 1'b1);    // retarget with nothing created
    issue(mk(REQ_ALLOC, 0, 0), 1'b1);
    issue(mk(REQ_ALLOC, TopId, TopId), 1'b1);
    issue(mk(REQ_CLAIM, 5, 0), 1'b1);       // fill the gap below 5 as free
    issue(mk(REQ_ALLOC, 0, 0), 1'b1);       // pop the top of the stack
    issue(mk(REQ_CLAIM, 3, 0), 1'b1);       // pull a freed ID from the top of the stack
    issue(mk(REQ_CLAIM, 1, 0), 1'b1);       // add a reference to a held ID
    issue(mk(REQ_RELEASE, 1, 0), 1'b1);
    issue(mk(REQ_RELEASE, 1, 0), 1'b1);     // count reaches zero, ID freed
    issue(mk(REQ_RELEASE, 1, 0), 1'b1);     // release at zero count
    issue(mk(REQ_RETARGET, 0, 1), 1'b1);    // old ID at zero count
    issue(mk(REQ_RETARGET, 6, 0), 1'b1);    // new ID not created yet
    issue(mk(REQ_RETARGET, 1, 0), 1'b1);    // new ID at zero count
    issue(mk(REQ_RETARGET, 5, 0), 1'b1);    // plain move of a reference
    issue(mk(REQ_RETARGET, 5, 5), 1'b1);    // same ID, count above one
    issue(mk(REQ_RETARGET, 3, 3), 1'b1);    // same ID, count of one
    issue(mk(REQ_CLAIM, 2, 0), 1'b1);       // freed ID at the stack bottom
    issue(mk(REQ_RELEASE, TopId, TopId), 1'b1);
    issue(mk(REQ_RETARGET, 2, TopId), 1'b1);
    issue(mk(REQ_ALLOC, 0, 0), 1'b1);

    // Random traffic, with stretches of back-to-back transactions.
    for (int unsigned i = 0; i < RandItems; i++) begin
      if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
      issue(rand_request(), !burst);
    end

    // Let everything settle before the full-table phase.
    drain();
    pause($urandom_range(1, 8));

    // Create every ID, then exercise the top ID and drain the free stack.
    issue(mk(REQ_CLAIM, TopId, 0), 1'b1);
    issue(mk(REQ_RELEASE, TopId, TopId), 1'b1);
    issue(mk(REQ_CLAIM, TopId, TopId), 1'b1);
    while (board.free_q.size() > 0)
      issue(mk(REQ_ALLOC, $urandom_range(0, TopId), $urandom_range(0, TopId)),
            $urandom_range(0, 3) == 0);
    issue(mk(REQ_ALLOC, 0, 0), 1'b1);       // table full
    issue(mk(REQ_CLAIM, 0, 0), 1'b1);       // claim with the stack empty

    // Retarget and release around the top ID on a full table.
    issue(mk(REQ_RETARGET, TopId, 0), 1'b1);
    issue(mk(REQ_RETARGET, TopId, TopId), 1'b1);
    issue(mk(REQ_RELEASE, TopId, 0), 1'b1);
    issue(mk(REQ_RETARGET, TopId, 0), 1'b1);

    drain();
    repeat (16) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ refcounted_id_allocator.f @@
rtl/rca_pkg.sv
rtl/rca_ram.sv
rtl/refcounted_id_allocator.sv
rtl/rca_checker.sv
test/tb.sv
